// ----- src/rfa_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_pkg: shared types and constants of the page frame allocator
// command and status codes, transaction payload structs, default sizes
// ----------------------------------------------------------------------------
package rfa_pkg;

	localparam int NUM_PAGES_DEF = 4096;
	localparam int PAGE_W        = 12;
	localparam int COUNT_W       = 16;
	localparam int CFG_W         = 12;
	localparam logic [CFG_W-1:0] FIRST_FREE_RST = 12'd1;

	typedef enum logic [1:0] {
		CMD_INIT    = 2'd0,
		CMD_ALLOC   = 2'd1,
		CMD_ADD_REF = 2'd2,
		CMD_RELEASE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		STS_OK           = 2'd0,
		STS_EMPTY        = 2'd1,
		STS_ZERO_RELEASE = 2'd2,
		STS_SATURATED    = 2'd3
	} status_t;

	typedef struct packed {
		cmd_t              command;
		logic [PAGE_W-1:0] page_index;
	} cmd_item_t;

	typedef struct packed {
		logic [PAGE_W-1:0]  granted_page;
		status_t            status;
		logic [COUNT_W-1:0] new_count;
		logic               page_freed;
	} rsp_item_t;

endpackage
`default_nettype wire

// ----- src/rfa_ram.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_ram: simple dual port synchronous ram
// one write port, one read port, read data registered and held between reads
// ----------------------------------------------------------------------------
module rfa_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096,
	parameter int AW    = 12
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic             re,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule
`default_nettype wire

// ----- src/rfa_ctrl.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// rfa_ctrl: allocator sequencer
// holds the list head, the link and count memories, and runs the
// read-modify-write of each command and the clearing / list build sweep
// ----------------------------------------------------------------------------
module rfa_ctrl #(
	parameter int NUM_PAGES = rfa_pkg::NUM_PAGES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire rfa_pkg::cmd_item_t         cmd,
	input  wire logic [rfa_pkg::CFG_W-1:0]  first_free_page,
	output logic                            res_valid,
	input  wire logic                       res_ready,
	output rfa_pkg::rsp_item_t              res
);

	import rfa_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int LW = PW + 1;
	localparam logic [LW-1:0] LIST_END  = LW'(NUM_PAGES);
	localparam logic [PW-1:0] LAST_PAGE = PW'(NUM_PAGES - 1);
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

	typedef enum logic [2:0] {
		ST_SWEEP = 3'b001,
		ST_IDLE  = 3'b010,
		ST_EXEC  = 3'b100
	} state_t;

	state_t              state_q;
	logic [PW-1:0]       sweep_idx_q;
	logic                sweep_init_q;
	logic [LW-1:0]       head_q;
	logic [LW-1:0]       head_d;
	cmd_t                cmd_s1;
	logic [PAGE_W-1:0]   page_s1;

	logic                accept;
	logic                fire;
	logic                head_empty;
	logic                page_ok_in;
	logic                page_ok_s1;
	logic                sweep_link;

	logic                link_we, link_re;
	logic [PW-1:0]       link_waddr, link_raddr;
	logic [LW-1:0]       link_wdata, link_rdata;
	logic                cnt_we, cnt_re;
	logic [PW-1:0]       cnt_waddr, cnt_raddr;
	logic [COUNT_W-1:0]  cnt_wdata, cnt_rdata;

	assign cmd_ready  = (state_q == ST_IDLE);
	assign accept     = cmd_valid && cmd_ready;
	assign res_valid  = (state_q == ST_EXEC);
	assign fire       = res_valid && res_ready;
	assign head_empty = (head_q == LIST_END);
	assign page_ok_in = 32'(cmd.page_index) < 32'(NUM_PAGES);
	assign page_ok_s1 = 32'(page_s1) < 32'(NUM_PAGES);
	assign sweep_link = sweep_init_q && (32'(sweep_idx_q) >= 32'(first_free_page));

	// read phase: addresses come from the list head or the accepted transaction
	assign link_re    = accept && (cmd.command == CMD_ALLOC) && !head_empty;
	assign link_raddr = PW'(head_q);
	assign cnt_re     = accept && (((cmd.command == CMD_ALLOC) && !head_empty) ||
		(((cmd.command == CMD_ADD_REF) || (cmd.command == CMD_RELEASE)) && page_ok_in));
	assign cnt_raddr  = (cmd.command == CMD_ALLOC) ? PW'(head_q) : PW'(cmd.page_index);

	// modify-write phase and result
	always_comb begin
		res        = '0;
		res.status = STS_OK;
		head_d     = head_q;
		link_we    = 1'b0;
		link_waddr = PW'(page_s1);
		link_wdata = head_q;
		cnt_we     = 1'b0;
		cnt_waddr  = PW'(page_s1);
		cnt_wdata  = cnt_rdata;
		if (state_q == ST_SWEEP) begin
			cnt_we     = 1'b1;
			cnt_waddr  = sweep_idx_q;
			cnt_wdata  = '0;
			link_waddr = sweep_idx_q;
			if (sweep_link) begin
				link_we = 1'b1;
				head_d  = LW'(sweep_idx_q);
			end
		end else if (state_q == ST_EXEC) begin
			case (cmd_s1)
				CMD_INIT: begin
				end
				CMD_ALLOC: begin
					if (head_empty) begin
						res.status = STS_EMPTY;
					end else begin
						res.granted_page = PAGE_W'(head_q);
						res.new_count    = cnt_rdata;
						head_d           = link_rdata;
					end
				end
				CMD_ADD_REF: begin
					if (!page_ok_s1) begin
						res.status = STS_SATURATED;
					end else if (cnt_rdata == COUNT_MAX) begin
						res.status    = STS_SATURATED;
						res.new_count = COUNT_MAX;
					end else begin
						cnt_we        = fire;
						cnt_wdata     = cnt_rdata + COUNT_W'(1);
						res.new_count = cnt_wdata;
					end
				end
				CMD_RELEASE: begin
					if (!page_ok_s1 || (cnt_rdata == '0)) begin
						res.status = STS_ZERO_RELEASE;
					end else begin
						cnt_we        = fire;
						cnt_wdata     = cnt_rdata - COUNT_W'(1);
						res.new_count = cnt_wdata;
						if (cnt_wdata == '0) begin
							// last reference gone: push page on the list
							link_we        = fire;
							head_d         = LW'(page_s1);
							res.page_freed = 1'b1;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1  <= cmd.command;
			page_s1 <= cmd.page_index;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_SWEEP;
			sweep_idx_q  <= '0;
			sweep_init_q <= 1'b0;
			head_q       <= LIST_END;
		end else begin
			case (state_q)
				ST_SWEEP: begin
					head_q      <= head_d;
					sweep_idx_q <= sweep_idx_q + PW'(1);
					if (sweep_idx_q == LAST_PAGE) begin
						state_q <= sweep_init_q ? ST_EXEC : ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept) begin
						if (cmd.command == CMD_INIT) begin
							state_q      <= ST_SWEEP;
							sweep_idx_q  <= '0;
							sweep_init_q <= 1'b1;
							head_q       <= LIST_END;
						end else begin
							state_q <= ST_EXEC;
						end
					end
				end
				ST_EXEC: begin
					if (fire) begin
						head_q  <= head_d;
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	rfa_ram #(
		.WIDTH (LW),
		.DEPTH (NUM_PAGES),
		.AW    (PW)
	) u_link_ram (
		.clk   (clk),
		.we    (link_we),
		.waddr (link_waddr),
		.wdata (link_wdata),
		.re    (link_re),
		.raddr (link_raddr),
		.rdata (link_rdata)
	);

	rfa_ram #(
		.WIDTH (COUNT_W),
		.DEPTH (NUM_PAGES),
		.AW    (PW)
	) u_count_ram (
		.clk   (clk),
		.we    (cnt_we),
		.waddr (cnt_waddr),
		.wdata (cnt_wdata),
		.re    (cnt_re),
		.raddr (cnt_raddr),
		.rdata (cnt_rdata)
	);

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= LIST_END)
		else $error("list head beyond end marker");

	a_accept_leaves_idle: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (state_q != ST_IDLE))
		else $error("accepted transaction did not start work");

	a_free_pushes_head: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && res.page_freed) |=> (head_q == LW'($past(page_s1))))
		else $error("freed page not at list head");

	a_add_ref_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_we && (state_q == ST_EXEC) && (cmd_s1 == CMD_ADD_REF)) |-> (cnt_wdata != '0))
		else $error("add reference wrote a zero count");

	a_fire_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		fire |=> (state_q == ST_IDLE))
		else $error("sequencer did not return to idle after result");

endmodule
`default_nettype wire

// ----- src/refcounted_page_frame_allocator_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// refcounted_page_frame_allocator_top: page frame allocator with ref counts
// lifo free list of page indices plus a 16-bit reference count per page
// ----------------------------------------------------------------------------
// Each command transaction yields exactly one response transaction. Allocate,
// add reference and release read the entry when the command is taken (the
// count and link memories are synchronous rams with registered read data),
// then modify it and, once the output register has room, write it back and
// hand the response over. Init runs one page per cycle as it clears every
// count and threads the free list through the link memory. After reset the
// block runs a clearing pass over the count memory and holds cmd_ready low
// until it is done; the free list is empty until the first init command.
// first_free_page is written through cfg_we / cfg_wdata; the user must write
// it only while the block is idle (the block itself does not enforce this),
// and it takes effect at the next init. A finished response waits in the
// output register while the next command is taken.
module refcounted_page_frame_allocator_top #(
	parameter int NUM_PAGES = rfa_pkg::NUM_PAGES_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	// command channel
	input  wire logic                       cmd_valid,
	output logic                            cmd_ready,
	input  wire rfa_pkg::cmd_item_t         cmd,
	// response channel
	output logic                            rsp_valid,
	input  wire logic                       rsp_ready,
	output rfa_pkg::rsp_item_t              rsp,
	// configuration register write
	input  wire logic                       cfg_we,
	input  wire logic [rfa_pkg::CFG_W-1:0]  cfg_wdata
);

	import rfa_pkg::*;

	logic [CFG_W-1:0] first_free_q;
	logic             res_valid;
	logic             res_ready;
	rsp_item_t        res;
	logic             rsp_valid_q;
	rsp_item_t        rsp_q;

	// configuration register, reserved pages below it
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_free_q <= FIRST_FREE_RST;
		end else if (cfg_we) begin
			first_free_q <= cfg_wdata;
		end
	end

	// sequencer with the link and count memories
	rfa_ctrl #(
		.NUM_PAGES (NUM_PAGES)
	) u_ctrl (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd_ready       (cmd_ready),
		.cmd             (cmd),
		.first_free_page (first_free_q),
		.res_valid       (res_valid),
		.res_ready       (res_ready),
		.res             (res)
	);

	// output register: slot frees when empty or being drained this cycle
	assign res_ready = !rsp_valid_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (res_valid && res_ready) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (res_valid && res_ready) begin
			rsp_q <= res;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire
